### rtl/aws_pkg.sv
// Shared types, constants and helpers for the accelerometer window statistics block.
// Used by every module under rtl except aws_ram; depends on nothing.
`default_nettype none
package aws_pkg;

  localparam int SHORT_LEN    = 20;
  localparam int LONG_LEN     = 100;
  localparam int HALF_SPAN    = 50;
  localparam int SAMPLE_WIDTH = 16;
  localparam int NUM_AXES     = 3;

  localparam int SPAN2    = 2 * HALF_SPAN;
  localparam int HMAX1    = (LONG_LEN > SPAN2) ? LONG_LEN : SPAN2;
  localparam int HIST_LEN = (HMAX1 > SHORT_LEN) ? HMAX1 : SHORT_LEN;

  localparam int PTR_W   = $clog2(HIST_LEN);
  localparam int COUNT_W = $clog2(HIST_LEN + 1);
  localparam int FLUSH_W = $clog2(HALF_SPAN);
  localparam int SSUM_W  = SAMPLE_WIDTH + $clog2(SHORT_LEN);
  localparam int LSUM_W  = SAMPLE_WIDTH + $clog2(LONG_LEN);
  localparam int DIV_W   = (LSUM_W > SSUM_W) ? LSUM_W : SSUM_W;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] REG_DEFAULT_X = 2'd0;
  localparam logic [1:0] REG_DEFAULT_Y = 2'd1;
  localparam logic [1:0] REG_DEFAULT_Z = 2'd2;

  localparam logic signed [SAMPLE_WIDTH-1:0] DEFAULT_X_RST = SAMPLE_WIDTH'(0);
  localparam logic signed [SAMPLE_WIDTH-1:0] DEFAULT_Y_RST = SAMPLE_WIDTH'(768);
  localparam logic signed [SAMPLE_WIDTH-1:0] DEFAULT_Z_RST = SAMPLE_WIDTH'(2355);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic [1:0] opcode;
    sample_t    accel_x;
    sample_t    accel_y;
    sample_t    accel_z;
    logic       missing_x;
    logic       missing_y;
    logic       missing_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] axis;
    sample_t    mean_short;
    sample_t    mean_long;
    logic       mean_valid;
    sample_t    window_min;
    sample_t    window_max;
    logic       window_valid;
    logic       last_of_run;
  } out_item_t;

  // what the delayed read data is used for
  typedef enum logic [1:0] {
    TAG_SHORT    = 2'd0,
    TAG_LONG     = 2'd1,
    TAG_MM_FIRST = 2'd2,
    TAG_MM       = 2'd3
  } rd_tag_t;

  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    rd_tag_t            rd_tag;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               add_new;
    logic               div_start;
    logic [COUNT_W-1:0] short_n;
    logic [COUNT_W-1:0] long_n;
  } lane_ctrl_t;

  typedef struct packed {
    logic div_busy;
  } lane_stat_t;

  typedef struct packed {
    sample_t mean_short;
    sample_t mean_long;
    sample_t window_min;
    sample_t window_max;
  } lane_res_t;

  // ring pointer plus an offset below HIST_LEN, wrapped
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W:0] k);
    logic [PTR_W+1:0] s;
    s = {2'b00, p} + {1'b0, k};
    if (s >= (PTR_W+2)'(HIST_LEN)) s = s - (PTR_W+2)'(HIST_LEN);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(HIST_LEN - 1);
    else r = p - PTR_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/aws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none
module aws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/aws_div.sv
// Radix-2 restoring divider, signed sum by unsigned count, truncating toward zero.
// Depends on aws_pkg.
`default_nettype none
module aws_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [aws_pkg::DIV_W-1:0] dividend,
  input  wire logic [aws_pkg::COUNT_W-1:0]      divisor,
  output logic                                  busy,
  output aws_pkg::sample_t                      quotient
);
  import aws_pkg::*;

  localparam int ITER_W = $clog2(DIV_W + 1);

  logic [ITER_W-1:0]  iter;
  logic [DIV_W-1:0]   quo;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dsr;
  logic               neg;

  logic [COUNT_W:0]   rem_sh;
  logic               fits;
  logic [DIV_W-1:0]   mag;
  logic [DIV_W-1:0]   signed_q;

  always_comb begin
    rem_sh   = {rem, quo[DIV_W-1]};
    fits     = (rem_sh >= {1'b0, dsr});
    mag      = dividend[DIV_W-1] ? (~dividend + DIV_W'(1)) : dividend;
    signed_q = neg ? (~quo + DIV_W'(1)) : quo;
    quotient = signed_q[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITER_W'(DIV_W);
      quo  <= mag;
      rem  <= '0;
      dsr  <= divisor;
      neg  <= dividend[DIV_W-1];
    end else if (busy) begin
      quo  <= {quo[DIV_W-2:0], fits};
      rem  <= fits ? COUNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[COUNT_W-1:0];
      iter <= iter - ITER_W'(1);
      if (iter == ITER_W'(1)) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/aws_lane.sv
// One axis lane: sample ring, running sums, min/max walk and two mean dividers.
// Depends on aws_pkg, aws_ram and aws_div.
`default_nettype none
module aws_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire aws_pkg::lane_ctrl_t ctrl,
  input  wire aws_pkg::sample_t    sample,
  output aws_pkg::lane_stat_t      stat,
  output aws_pkg::lane_res_t       res
);
  import aws_pkg::*;

  logic [SAMPLE_WIDTH-1:0]   rd_raw;
  sample_t                   rdata;
  logic                      rd_vld;
  rd_tag_t                   tag_d;
  logic signed [SSUM_W-1:0]  short_sum;
  logic signed [LSUM_W-1:0]  long_sum;
  sample_t                   lo;
  sample_t                   hi;
  logic                      busy_s;
  logic                      busy_l;

  aws_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HIST_LEN)) u_ring (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (ctrl.wr_addr),
    .wr_data (sample),
    .rd_en   (ctrl.rd_en),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rd_raw)
  );

  assign rdata = rd_raw;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      rd_vld    <= 1'b0;
      short_sum <= '0;
      long_sum  <= '0;
    end else begin
      rd_vld <= ctrl.rd_en;
      tag_d  <= ctrl.rd_tag;
      // expiring entries come back in the cycle after their read
      short_sum <= short_sum
                 + (ctrl.add_new ? SSUM_W'(sample) : '0)
                 - ((rd_vld && tag_d == TAG_SHORT) ? SSUM_W'(rdata) : '0);
      long_sum  <= long_sum
                 + (ctrl.add_new ? LSUM_W'(sample) : '0)
                 - ((rd_vld && tag_d == TAG_LONG) ? LSUM_W'(rdata) : '0);
      if (rd_vld && tag_d == TAG_MM_FIRST) begin
        lo <= rdata;
        hi <= rdata;
      end else if (rd_vld && tag_d == TAG_MM) begin
        if (rdata < lo) lo <= rdata;
        if (rdata > hi) hi <= rdata;
      end
    end
  end

  aws_div u_div_short (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (DIV_W'(short_sum)),
    .divisor  (ctrl.short_n),
    .busy     (busy_s),
    .quotient (res.mean_short)
  );

  aws_div u_div_long (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (DIV_W'(long_sum)),
    .divisor  (ctrl.long_n),
    .busy     (busy_l),
    .quotient (res.mean_long)
  );

  assign res.window_min = lo;
  assign res.window_max = hi;
  assign stat.div_busy  = busy_s | busy_l;

endmodule
`default_nettype wire

### rtl/aws_merge.sv
// Result stage: holds the three lane results and sends them out x, y, z.
// Depends on aws_pkg.
`default_nettype none
module aws_merge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic                mean_valid,
  input  wire logic                window_valid,
  input  wire aws_pkg::lane_res_t  lane_res [aws_pkg::NUM_AXES],
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aws_pkg::out_item_t       out_data
);
  import aws_pkg::*;

  lane_res_t  held [NUM_AXES];
  logic       mv;
  logic       wv;
  logic [1:0] axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      axis      <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      axis      <= 2'd0;
      mv        <= mean_valid;
      wv        <= window_valid;
      for (int a = 0; a < NUM_AXES; a++) begin
        held[a].mean_short <= mean_valid ? lane_res[a].mean_short : '0;
        held[a].mean_long  <= mean_valid ? lane_res[a].mean_long : '0;
        held[a].window_min <= window_valid ? lane_res[a].window_min : '0;
        held[a].window_max <= window_valid ? lane_res[a].window_max : '0;
      end
    end else if (out_valid && out_ready) begin
      if (axis == 2'(NUM_AXES - 1)) out_valid <= 1'b0;
      else axis <= axis + 2'd1;
    end
  end

  always_comb begin
    out_data.axis         = axis;
    out_data.mean_short   = held[axis].mean_short;
    out_data.mean_long    = held[axis].mean_long;
    out_data.mean_valid   = mv;
    out_data.window_min   = held[axis].window_min;
    out_data.window_max   = held[axis].window_max;
    out_data.window_valid = wv;
    out_data.last_of_run  = (axis == 2'(NUM_AXES - 1));
  end

  assign busy = out_valid;

endmodule
`default_nettype wire

### rtl/accel_window_statistics.sv
// Accelerometer window statistics: trailing means and centred min/max per axis.
// Sample: control states, up to 100 ring reads and the two serial dividers.
// Flush: up to 100 ring reads. Clear: resets counts, the pointer and the sums.
// One item at a time; the min/max walk over the ring and the serial dividers set
// the pace. Results leave over three transfers and the next item may enter meanwhile.
// Synchronous reset clears sums, counts and pointers; ring contents stay undefined.
`default_nettype none
module accel_window_statistics (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire aws_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output aws_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import aws_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SHORT, S_LONG, S_WRITE, S_WALK, S_DRAIN, S_DIV, S_DIVW, S_OUT, S_CLEAR
  } state_t;

  state_t             state;
  sample_t            def_x, def_y, def_z;
  sample_t            smp [NUM_AXES];
  logic [COUNT_W-1:0] sample_count;
  logic [FLUSH_W-1:0] flush_count;
  logic [PTR_W-1:0]   long_pos;
  logic [PTR_W-1:0]   walk_ptr;
  logic [COUNT_W-1:0] walk_left;
  logic               walk_first;
  logic               mean_valid;
  logic               window_valid;

  lane_ctrl_t         ctrl;
  lane_stat_t         stat [NUM_AXES];
  lane_res_t          lane_res [NUM_AXES];
  logic               merge_busy;
  logic               load;
  logic               accept;

  logic [COUNT_W-1:0]       count_next;
  logic [COUNT_W-1:0]       flush_k;
  logic signed [COUNT_W+1:0] lo_edge;
  logic [COUNT_W-1:0]       flush_m;
  logic [COUNT_W-1:0]       walk_m;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load      = (state == S_OUT) && !merge_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      def_x <= DEFAULT_X_RST;
      def_y <= DEFAULT_Y_RST;
      def_z <= DEFAULT_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEFAULT_X: def_x <= cfg_data;
        REG_DEFAULT_Y: def_y <= cfg_data;
        REG_DEFAULT_Z: def_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_next = (sample_count < COUNT_W'(HIST_LEN)) ? sample_count + COUNT_W'(1)
                                                      : sample_count;
    walk_m  = (count_next < COUNT_W'(SPAN2)) ? count_next : COUNT_W'(SPAN2);
    flush_k = (sample_count < COUNT_W'(HALF_SPAN - 1)) ? sample_count
                                                       : COUNT_W'(HALF_SPAN - 1);
    lo_edge = $signed({2'b00, sample_count}) - $signed({2'b00, flush_k})
            + $signed((COUNT_W+2)'(flush_count)) - (COUNT_W+2)'(HALF_SPAN);
    if (lo_edge < 0) lo_edge = '0;
    flush_m = COUNT_W'($signed({2'b00, sample_count}) - lo_edge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      flush_count  <= '0;
      long_pos     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              OP_SAMPLE: begin
                smp[0] <= in_data.missing_x ? def_x : in_data.accel_x;
                smp[1] <= in_data.missing_y ? def_y : in_data.accel_y;
                smp[2] <= in_data.missing_z ? def_z : in_data.accel_z;
                state  <= S_SHORT;
              end
              OP_FLUSH: begin
                if (COUNT_W'(flush_count) < flush_k) begin
                  walk_ptr     <= ptr_dec(long_pos);
                  walk_left    <= flush_m;
                  walk_first   <= 1'b1;
                  mean_valid   <= 1'b0;
                  window_valid <= 1'b1;
                  flush_count  <= flush_count + FLUSH_W'(1);
                  state        <= S_WALK;
                end
              end
              OP_CLEAR: begin
                sample_count <= '0;
                flush_count  <= '0;
                long_pos     <= '0;
                state        <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_SHORT: state <= S_LONG;
        S_LONG:  state <= S_WRITE;
        S_WRITE: begin
          long_pos     <= ptr_add(long_pos, (PTR_W+1)'(1));
          sample_count <= count_next;
          flush_count  <= '0;
          walk_ptr     <= long_pos;
          walk_left    <= walk_m;
          walk_first   <= 1'b1;
          mean_valid   <= 1'b1;
          window_valid <= (count_next >= COUNT_W'(HALF_SPAN));
          state        <= (count_next >= COUNT_W'(HALF_SPAN)) ? S_WALK : S_DIV;
        end
        S_WALK: begin
          walk_ptr   <= ptr_dec(walk_ptr);
          walk_left  <= walk_left - COUNT_W'(1);
          walk_first <= 1'b0;
          if (walk_left == COUNT_W'(1)) state <= S_DRAIN;
        end
        S_DRAIN: state <= mean_valid ? S_DIV : S_OUT;
        S_DIV:   state <= S_DIVW;
        S_DIVW:  if (!stat[0].div_busy) state <= S_OUT;
        S_OUT:   if (!merge_busy) state <= S_IDLE;
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.rd_tag    = TAG_MM;
    ctrl.wr_addr   = long_pos;
    ctrl.rd_addr   = walk_ptr;
    ctrl.short_n   = (sample_count < COUNT_W'(SHORT_LEN)) ? sample_count
                                                          : COUNT_W'(SHORT_LEN);
    ctrl.long_n    = (sample_count < COUNT_W'(LONG_LEN)) ? sample_count
                                                         : COUNT_W'(LONG_LEN);
    ctrl.clear     = (state == S_CLEAR);
    ctrl.div_start = (state == S_DIV);
    unique case (state)
      S_SHORT: begin
        ctrl.rd_en   = (sample_count >= COUNT_W'(SHORT_LEN));
        ctrl.rd_addr = ptr_add(long_pos, (PTR_W+1)'(HIST_LEN - SHORT_LEN));
        ctrl.rd_tag  = TAG_SHORT;
      end
      S_LONG: begin
        ctrl.rd_en   = (sample_count >= COUNT_W'(LONG_LEN));
        ctrl.rd_addr = ptr_add(long_pos, (PTR_W+1)'(HIST_LEN - LONG_LEN));
        ctrl.rd_tag  = TAG_LONG;
      end
      S_WRITE: begin
        ctrl.wr_en   = 1'b1;
        ctrl.add_new = 1'b1;
      end
      S_WALK: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_tag = walk_first ? TAG_MM_FIRST : TAG_MM;
      end
      default: ;
    endcase
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    aws_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .sample (smp[a]),
      .stat   (stat[a]),
      .res    (lane_res[a])
    );
  end

  aws_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .mean_valid   (mean_valid),
    .window_valid (window_valid),
    .lane_res     (lane_res),
    .busy         (merge_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(HIST_LEN)) else $error("sample count past ring depth");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    COUNT_W'(flush_count) < COUNT_W'(HALF_SPAN)) else $error("flush count out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.opcode == OP_CLEAR |=> sample_count == '0 && long_pos == '0)
    else $error("clear did not reset counters");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    stat[0].div_busy |-> state == S_DIVW) else $error("divider busy outside wait");

endmodule
`default_nettype wire
